@@ hdl/hkd_pkg.sv @@
// ----------------------------------------------------------------------------
// hkd_pkg
// Types, constants and the key usage to ASCII translation shared by the
// boot keyboard report event decoder.
// ----------------------------------------------------------------------------
package hkd_pkg;

    localparam int KEY_SLOTS   = 6;                       // slots in use, 1..6
    localparam int MAX_SLOTS   = 6;                       // slots in a report
    localparam int MOD_BITS    = 8;
    localparam int EV_BITS     = MOD_BITS + 2 * KEY_SLOTS;
    localparam int QUEUE_DEPTH = 2;                       // power of two
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] MOD_BASE   = 8'hE0;
    localparam logic [7:0] SHIFT_KEYS = 8'h22;            // left or right shift

    typedef logic [KEY_SLOTS-1:0][7:0] t_slots;

    typedef struct packed {
        logic [7:0] modifier_bits;
        logic [7:0] key_slot_0;
        logic [7:0] key_slot_1;
        logic [7:0] key_slot_2;
        logic [7:0] key_slot_3;
        logic [7:0] key_slot_4;
        logic [7:0] key_slot_5;
    } t_in_item;

    typedef struct packed {
        logic [7:0] key_code;
        logic       pressed;
        logic [6:0] ascii_char;
        logic       last_event;
    } t_out_item;

    // One classified report: which events fire, plus what is needed to build them.
    typedef struct packed {
        logic [EV_BITS-1:0] mask;
        logic [7:0]         mods;
        t_slots             prev;
        t_slots             cur;
        logic               shift;
    } t_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic key_present(input logic [7:0] code, input t_slots slots);
        logic hit;
        hit = 1'b0;
        for (int s = 0; s < KEY_SLOTS; s++) begin
            if (slots[s] == code) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic [6:0] to_ascii(input logic [7:0] code, input logic shift);
        logic [5:0] idx;
        logic [7:0] ch;
        idx = code[5:0];
        ch  = 8'h00;
        if (code[7:6] == 2'b00) begin
            if (idx >= 6'd4 && idx <= 6'd29) begin
                ch = (shift ? 8'h41 : 8'h61) + {2'b00, idx} - 8'd4;
            end else begin
                case (idx)
                    6'd30:   ch = shift ? 8'h21 : 8'h31;
                    6'd31:   ch = shift ? 8'h40 : 8'h32;
                    6'd32:   ch = shift ? 8'h23 : 8'h33;
                    6'd33:   ch = shift ? 8'h24 : 8'h34;
                    6'd34:   ch = shift ? 8'h25 : 8'h35;
                    6'd35:   ch = shift ? 8'h5E : 8'h36;
                    6'd36:   ch = shift ? 8'h26 : 8'h37;
                    6'd37:   ch = shift ? 8'h2A : 8'h38;
                    6'd38:   ch = shift ? 8'h28 : 8'h39;
                    6'd39:   ch = shift ? 8'h29 : 8'h30;
                    6'd40:   ch = shift ? 8'h00 : 8'h0A;
                    6'd41:   ch = shift ? 8'h00 : 8'h1B;
                    6'd42:   ch = shift ? 8'h00 : 8'h08;
                    6'd43:   ch = shift ? 8'h00 : 8'h09;
                    6'd44:   ch = shift ? 8'h00 : 8'h20;
                    6'd45:   ch = shift ? 8'h5F : 8'h2D;
                    6'd46:   ch = shift ? 8'h2B : 8'h3D;
                    6'd47:   ch = shift ? 8'h7B : 8'h5B;
                    6'd48:   ch = shift ? 8'h7D : 8'h5D;
                    6'd49:   ch = shift ? 8'h7C : 8'h5C;
                    6'd51:   ch = shift ? 8'h3A : 8'h3B;
                    6'd52:   ch = shift ? 8'h22 : 8'h27;
                    6'd53:   ch = shift ? 8'h7E : 8'h60;
                    6'd54:   ch = shift ? 8'h3C : 8'h2C;
                    6'd55:   ch = shift ? 8'h3E : 8'h2E;
                    6'd56:   ch = shift ? 8'h3F : 8'h2F;
                    default: ch = 8'h00;
                endcase
            end
        end
        return ch[6:0];
    endfunction

endpackage

@@ hdl/hkd_front.sv @@
// ----------------------------------------------------------------------------
// hkd_front
// Accepts reports, compares them with the stored previous report and pushes
// a descriptor of the events to fire into the queue.
// ----------------------------------------------------------------------------
module hkd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hkd_pkg::t_in_item i_in_item,
    input  logic              i_q_full,
    output logic              o_push,
    output hkd_pkg::t_desc    o_desc
);
    import hkd_pkg::*;

    logic [MAX_SLOTS-1:0][7:0] all_slots;
    t_slots                    cur;
    logic [7:0]                r_prev_mods, n_prev_mods;
    t_slots                    r_prev_keys, n_prev_keys;
    logic [EV_BITS-1:0]        mask;
    logic                      accept;

    assign all_slots = {i_in_item.key_slot_5, i_in_item.key_slot_4, i_in_item.key_slot_3,
                        i_in_item.key_slot_2, i_in_item.key_slot_1, i_in_item.key_slot_0};

    always_comb begin
        for (int s = 0; s < KEY_SLOTS; s++) begin
            cur[s] = all_slots[s];
        end
    end

    always_comb begin
        mask[MOD_BITS-1:0] = r_prev_mods ^ i_in_item.modifier_bits;
        for (int s = 0; s < KEY_SLOTS; s++) begin
            mask[MOD_BITS + s] = (r_prev_keys[s] != 8'd0) &&
                                 !key_present(r_prev_keys[s], cur);
            mask[MOD_BITS + KEY_SLOTS + s] = (cur[s] != 8'd0) &&
                                             !key_present(cur[s], r_prev_keys);
        end
    end

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    // a report with no change causes no transaction downstream
    assign o_push     = accept && (|mask);

    assign o_desc.mask  = mask;
    assign o_desc.mods  = i_in_item.modifier_bits;
    assign o_desc.prev  = r_prev_keys;
    assign o_desc.cur   = cur;
    assign o_desc.shift = |(i_in_item.modifier_bits & SHIFT_KEYS);

    assign n_prev_mods = accept ? i_in_item.modifier_bits : r_prev_mods;
    assign n_prev_keys = accept ? cur : r_prev_keys;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_mods <= '0;
            r_prev_keys <= '0;
        end else begin
            r_prev_mods <= n_prev_mods;
            r_prev_keys <= n_prev_keys;
        end
    end

endmodule

@@ hdl/hkd_queue.sv @@
// ----------------------------------------------------------------------------
// hkd_queue
// Short descriptor queue between the classifying front and the event back.
// ----------------------------------------------------------------------------
module hkd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  hkd_pkg::t_desc     i_desc,
    input  logic               i_pop,
    output hkd_pkg::t_desc     o_head,
    output hkd_pkg::t_q_status o_status
);
    import hkd_pkg::*;

    t_desc             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QPTR_W:0]   r_count, n_count;
    logic              do_push;
    logic              do_pop;

    assign o_status.full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_comb begin
        n_wr    = do_push ? r_wr + 1'b1 : r_wr;
        n_rd    = do_pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

@@ hdl/hkd_back.sv @@
// ----------------------------------------------------------------------------
// hkd_back
// Takes one descriptor at a time and emits its events in order, one per
// cycle while the output is not stalled, through a registered output.
// ----------------------------------------------------------------------------
module hkd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hkd_pkg::t_desc     i_head,
    input  hkd_pkg::t_q_status i_status,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hkd_pkg::t_out_item o_out_item
);
    import hkd_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    t_state             r_state, n_state;
    t_desc              r_desc, n_desc;
    logic [EV_BITS-1:0] r_rem, n_rem;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_item, n_out_item;
    logic [EV_BITS-1:0] pick;
    logic               emit;
    t_out_item          ev;

    // lowest pending event bit, one-hot
    assign pick = r_rem & (~r_rem + 1'b1);
    assign emit = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);
    assign o_pop = (r_state == ST_IDLE) && !i_status.empty;

    always_comb begin
        ev.key_code   = '0;
        ev.pressed    = 1'b0;
        ev.ascii_char = '0;
        ev.last_event = ((r_rem & ~pick) == '0);
        for (int b = 0; b < MOD_BITS; b++) begin
            if (pick[b]) begin
                ev.key_code = MOD_BASE + 8'(b);
                ev.pressed  = r_desc.mods[b];
            end
        end
        for (int s = 0; s < KEY_SLOTS; s++) begin
            if (pick[MOD_BITS + s]) begin
                ev.key_code = r_desc.prev[s];
            end
            if (pick[MOD_BITS + KEY_SLOTS + s]) begin
                ev.key_code = r_desc.cur[s];
                ev.pressed  = 1'b1;
            end
        end
        if (ev.pressed && (pick[MOD_BITS-1:0] == '0)) begin
            ev.ascii_char = to_ascii(ev.key_code, r_desc.shift);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_desc      = r_desc;
        n_rem       = r_rem;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    n_desc  = i_head;
                    n_rem   = i_head.mask;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit) begin
                    n_out_valid = 1'b1;
                    n_out_item  = ev;
                    n_rem       = r_rem & ~pick;
                    if (ev.last_event) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_desc     <= n_desc;
        r_rem      <= n_rem;
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ hdl/hid_keyboard_report_event_decoder.sv @@
// ----------------------------------------------------------------------------
// hid_keyboard_report_event_decoder
// Boot keyboard report decoder: turns each report into modifier, release and
// press events against the previous report, with ASCII on key presses.
// ----------------------------------------------------------------------------
// Path: descriptor queue, back end descriptor register, then output register.
// A report with N events (N up to 20) leaves the back end one event per cycle
// while the output is not stalled; a report with no change pushes nothing.
// Input ready drops only while the two-entry descriptor queue is full.
// Reset: stored previous report cleared to zero, queue and output emptied.
module hid_keyboard_report_event_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hkd_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hkd_pkg::t_out_item o_out_item
);
    import hkd_pkg::*;

    logic      push;
    logic      pop;
    t_desc     push_desc;
    t_desc     head_desc;
    t_q_status q_status;

    hkd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (q_status.full),
        .o_push     (push),
        .o_desc     (push_desc)
    );

    hkd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_desc   (push_desc),
        .i_pop    (pop),
        .o_head   (head_desc),
        .o_status (q_status)
    );

    hkd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_desc),
        .i_status    (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

@@ hdl/hkd_checker.sv @@
// ----------------------------------------------------------------------------
// hkd_checker
// Port-level checks for the boot keyboard report event decoder.
// ----------------------------------------------------------------------------
module hkd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input hkd_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input hkd_pkg::t_out_item o_out_item
);
    import hkd_pkg::*;

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result dropped or changed while stalled");

    // a character only rides on a press
    a_ascii_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.ascii_char != 7'd0) |-> o_out_item.pressed)
        else $error("ascii character on a release or empty event");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready right after reset");

endmodule

bind hid_keyboard_report_event_decoder hkd_checker u_checker (.*);
